>>> design/vertex_rotate_project_defines.svh
// Assertion macros for the vertex transform block.
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst is high.
`define VRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VRP_ASSERT_NOW(lbl, ante, cons, msg)
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> design/vrp_pkg.sv
package vrp_pkg;

  // field widths
  localparam int VTX_W   = 13;  // Q10 vertex coordinate, signed
  localparam int OUT_W   = 21;  // screen coordinate, signed
  localparam int ANG_W   = 9;   // angle register
  localparam int DIM_W   = 13;  // screen size register
  localparam int TRIG_W  = 12;  // Q10 sine / cosine, signed, |v| <= 1024
  localparam int SCALE_W = 12;  // floor(h * 2 / 5) <= 3276
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  // datapath widths
  localparam int ROT_W   = 15;  // rotated coordinate, |v| <= 12288
  localparam int DEPTH_W = 14;  // clamped depth, 16..15360
  localparam int DIVN_W  = 26;  // |rotated * scale| < 2^26

  // setup divider widths
  localparam int SET_N_W = 25;  // 4096 * t <= 33177600
  localparam int SET_D_W = 16;  // 40500 - t
  localparam int T_W     = 13;  // t = a * (180 - a) <= 8100
  localparam int SIN_SHIFT = 12; // 4 * Q10 one

  localparam int FULL_TURN    = 360;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;
  localparam int BHASKARA_K   = 40500;
  localparam int Q10_SHIFT    = 10;
  localparam int DEPTH_OFFSET = 3 * 1024;
  localparam int DEPTH_MIN    = 16;
  localparam int SCALE_DEN    = 5;
  localparam int OUT_MAX      = 1048575;
  localparam int OUT_MIN      = -1048576;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 8'd3;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // word handed to the projection divider
  typedef struct packed {
    logic              valid;
    logic              neg_x;
    logic              neg_y;
    logic [DIVN_W-1:0] mag_x;
    logic [DIVN_W-1:0] mag_y;
    logic [DEPTH_W-1:0] divisor;
  } vrp_div_in_t;

  typedef struct packed {
    logic              valid;
    logic              neg_x;
    logic              neg_y;
    logic [DIVN_W-1:0] quot_x;
    logic [DIVN_W-1:0] quot_y;
  } vrp_div_out_t;

endpackage

>>> design/vertex_rotate_project.sv
// Path: an accepted vertex passes 7 transform stages, 26 quotient stages of the
// projection divider and 1 output register before its result strobe.
// Throughput: one vertex per cycle; busy is high only while sine, cosine and scale are
// rebuilt by a serial divider: after reset and after each write of an angle
// or the height. Results cannot be stalled. Synchronous active-high reset.
module vertex_rotate_project
  import vrp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [VTX_W-1:0]     vertex_x,
  input  logic signed [VTX_W-1:0]     vertex_y,
  input  logic signed [VTX_W-1:0]     vertex_z,
  output logic                        result_strobe,
  output logic signed [OUT_W-1:0]     screen_x,
  output logic signed [OUT_W-1:0]     screen_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data
);

  localparam int PIPE_DEPTH = 8 + DIVN_W;
  localparam int BIT_W = $clog2(SET_N_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam logic [2:0] STEP_SIN_Y = 3'd0;
  localparam logic [2:0] STEP_COS_Y = 3'd1;
  localparam logic [2:0] STEP_SIN_X = 3'd2;
  localparam logic [2:0] STEP_COS_X = 3'd3;
  localparam logic [2:0] STEP_SCALE = 3'd4;

  // ---------------- configuration and setup ----------------
  logic [ANG_W-1:0] angle_y_deg;
  logic [ANG_W-1:0] angle_x_deg;
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;

  logic [1:0]       set_state;
  logic [2:0]       step;
  logic [BIT_W-1:0] bit_cnt;
  logic [SET_N_W-1:0] set_nq;
  logic [SET_D_W-1:0] set_den;
  logic [SET_D_W-1:0] set_rem;
  logic               set_neg;

  logic signed [TRIG_W-1:0] sin_y, cos_y, sin_x, cos_x;
  logic [SCALE_W-1:0]       scale;

  logic cfg_write;
  logic cfg_restart;
  logic last_bit;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_write && (cfg_index == REG_ANGLE_Y || cfg_index == REG_ANGLE_X ||
                                     cfg_index == REG_HEIGHT);
  assign busy = (set_state != ST_IDLE);
  assign last_bit = (bit_cnt == BIT_W'(SET_N_W - 1));

  // operands for the current setup step
  logic [ANG_W-1:0]   ang_src, ang_red, ang_fold;
  logic [ANG_W:0]     ang_shift;
  logic [7:0]         ang_mag;
  logic               ang_neg;
  logic [15:0]        t_full;
  logic [T_W-1:0]     t_val;
  logic [SET_N_W-1:0] prep_num;
  logic [SET_D_W-1:0] prep_den;
  logic               prep_neg;

  always_comb begin
    ang_src = (step == STEP_SIN_Y || step == STEP_COS_Y) ? angle_y_deg : angle_x_deg;
    ang_red = (ang_src >= ANG_W'(FULL_TURN)) ? ANG_W'(ang_src - ANG_W'(FULL_TURN)) : ang_src;
    ang_shift = {1'b0, ang_red} +
                ((step == STEP_COS_Y || step == STEP_COS_X) ? 10'(QUARTER_TURN) : 10'd0);
    ang_fold = (ang_shift >= 10'(FULL_TURN)) ? ANG_W'(ang_shift - 10'(FULL_TURN))
                                             : ANG_W'(ang_shift);
    if (ang_fold > ANG_W'(HALF_TURN)) begin
      ang_mag = 8'(ang_fold - ANG_W'(HALF_TURN));
      ang_neg = 1'b1;
    end else begin
      ang_mag = 8'(ang_fold);
      ang_neg = 1'b0;
    end
    t_full = 16'(ang_mag) * (16'(HALF_TURN) - 16'(ang_mag));
    t_val = T_W'(t_full);
    if (step == STEP_SCALE) begin
      prep_num = SET_N_W'({screen_height, 1'b0});
      prep_den = SET_D_W'(SCALE_DEN);
      prep_neg = 1'b0;
    end else begin
      prep_num = SET_N_W'(t_val) << SIN_SHIFT;
      prep_den = SET_D_W'(BHASKARA_K) - SET_D_W'(t_val);
      prep_neg = ang_neg;
    end
  end

  // one restoring step per cycle
  logic [SET_D_W:0]   set_trial;
  logic               set_ge;
  logic [SET_D_W-1:0] set_rem_next;
  logic [SET_N_W-1:0] set_nq_next;
  logic signed [TRIG_W-1:0] trig_next;

  always_comb begin
    set_trial = {set_rem, set_nq[SET_N_W-1]};
    set_ge = (set_trial >= {1'b0, set_den});
    set_rem_next = SET_D_W'(set_ge ? (set_trial - {1'b0, set_den}) : set_trial);
    set_nq_next = {set_nq[SET_N_W-2:0], set_ge};
    trig_next = set_neg ? -TRIG_W'(set_nq_next[TRIG_W-2:0])
                        : TRIG_W'(set_nq_next[TRIG_W-2:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_y_deg   <= '0;
      angle_x_deg   <= '0;
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      set_state     <= ST_PREP;
      step          <= STEP_SIN_Y;
      bit_cnt       <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ANGLE_Y: angle_y_deg   <= cfg_data[ANG_W-1:0];
          REG_ANGLE_X: angle_x_deg   <= cfg_data[ANG_W-1:0];
          REG_WIDTH:   screen_width  <= cfg_data[DIM_W-1:0];
          REG_HEIGHT:  screen_height <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
      if (cfg_restart) begin
        set_state <= ST_PREP;
        step      <= STEP_SIN_Y;
      end else begin
        unique case (set_state)
          ST_IDLE: ;
          ST_PREP: begin
            set_state <= ST_DIV;
            bit_cnt   <= '0;
          end
          ST_DIV: begin
            bit_cnt <= bit_cnt + 1'b1;
            if (last_bit) begin
              step      <= step + 1'b1;
              set_state <= (step == STEP_SCALE) ? ST_IDLE : ST_PREP;
            end
          end
          default: set_state <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_state == ST_PREP) begin
      set_nq  <= prep_num;
      set_den <= prep_den;
      set_rem <= '0;
      set_neg <= prep_neg;
    end else if (set_state == ST_DIV) begin
      set_nq  <= set_nq_next;
      set_rem <= set_rem_next;
      if (last_bit) begin
        unique case (step)
          STEP_SIN_Y: sin_y <= trig_next;
          STEP_COS_Y: cos_y <= trig_next;
          STEP_SIN_X: sin_x <= trig_next;
          STEP_COS_X: cos_x <= trig_next;
          STEP_SCALE: scale <= set_nq_next[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- transform pipeline ----------------
  logic accept;
  assign accept = start && !busy;

  logic v1, v2, v3, v4, v5, v6, v7, v_out;

  logic signed [VTX_W-1:0] x1, y1, z1, y2, y3;
  logic signed [VTX_W+TRIG_W-1:0] p_xc, p_zs, p_xs, p_zc;
  logic signed [ROT_W-1:0] xr3, zr3, xr4, xr5, yr5;
  logic signed [VTX_W+TRIG_W-1:0] p_yc, p_ys;
  logic signed [ROT_W+TRIG_W-1:0] p_zrs, p_zrc;
  logic [DEPTH_W-1:0] zc5, zc6, zc7;
  logic signed [ROT_W+SCALE_W:0] px6, py6;
  logic               neg_x7, neg_y7;
  logic [DIVN_W-1:0]  mag_x7, mag_y7;

  logic signed [VTX_W+TRIG_W:0]   xr_sum, zr_sum;
  logic signed [ROT_W+TRIG_W:0]   yr_sum, zr2_sum;
  logic signed [ROT_W-1:0]        zr2;
  logic signed [ROT_W:0]          zc_raw;

  always_comb begin
    xr_sum  = (VTX_W+TRIG_W+1)'(p_xc) + (VTX_W+TRIG_W+1)'(p_zs);
    zr_sum  = (VTX_W+TRIG_W+1)'(p_zc) - (VTX_W+TRIG_W+1)'(p_xs);
    yr_sum  = (ROT_W+TRIG_W+1)'(p_yc) - (ROT_W+TRIG_W+1)'(p_zrs);
    zr2_sum = (ROT_W+TRIG_W+1)'(p_ys) + (ROT_W+TRIG_W+1)'(p_zrc);
    zr2     = ROT_W'(zr2_sum >>> Q10_SHIFT);
    zc_raw  = (ROT_W+1)'(zr2) + (ROT_W+1)'(DEPTH_OFFSET);
  end

  logic signed [SCALE_W:0] scale_s;
  assign scale_s = signed'({1'b0, scale});

  vrp_div_in_t  div_in;
  vrp_div_out_t div_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v_out <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v_out <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    // s1: capture
    x1 <= vertex_x;
    y1 <= vertex_y;
    z1 <= vertex_z;
    // s2: rotation about Y, products
    p_xc <= x1 * cos_y;
    p_zs <= z1 * sin_y;
    p_xs <= x1 * sin_y;
    p_zc <= z1 * cos_y;
    y2   <= y1;
    // s3: floor shift back to Q10 coordinates
    xr3 <= ROT_W'(xr_sum >>> Q10_SHIFT);
    zr3 <= ROT_W'(zr_sum >>> Q10_SHIFT);
    y3  <= y2;
    // s4: rotation about X, products
    p_yc  <= y3 * cos_x;
    p_zrs <= zr3 * sin_x;
    p_ys  <= y3 * sin_x;
    p_zrc <= zr3 * cos_x;
    xr4   <= xr3;
    // s5: depth offset and near clamp
    yr5 <= ROT_W'(yr_sum >>> Q10_SHIFT);
    zc5 <= (zc_raw < (ROT_W+1)'(DEPTH_MIN)) ? DEPTH_W'(DEPTH_MIN) : DEPTH_W'(zc_raw);
    xr5 <= xr4;
    // s6: projection scale
    px6 <= xr5 * scale_s;
    py6 <= yr5 * scale_s;
    zc6 <= zc5;
    // s7: sign and magnitude for the divider
    neg_x7 <= px6[ROT_W+SCALE_W];
    neg_y7 <= py6[ROT_W+SCALE_W];
    mag_x7 <= DIVN_W'(px6[ROT_W+SCALE_W] ? -px6 : px6);
    mag_y7 <= DIVN_W'(py6[ROT_W+SCALE_W] ? -py6 : py6);
    zc7 <= zc6;
  end

  always_comb begin
    div_in.valid   = v7;
    div_in.neg_x   = neg_x7;
    div_in.neg_y   = neg_y7;
    div_in.mag_x   = mag_x7;
    div_in.mag_y   = mag_y7;
    div_in.divisor = zc7;
  end

  vrp_div_pipe u_div (
    .clk  (clk),
    .rst  (rst),
    .din  (div_in),
    .dout (div_out)
  );

  // centre and saturate; quotients truncate toward zero
  logic signed [DIVN_W:0]   qx, qy;
  logic signed [DIVN_W+1:0] sx_full, sy_full;
  logic signed [OUT_W-1:0]  sx_sat, sy_sat;

  always_comb begin
    qx = div_out.neg_x ? -(DIVN_W+1)'(div_out.quot_x) : (DIVN_W+1)'(div_out.quot_x);
    qy = div_out.neg_y ? -(DIVN_W+1)'(div_out.quot_y) : (DIVN_W+1)'(div_out.quot_y);
    sx_full = (DIVN_W+2)'({1'b0, screen_width[DIM_W-1:1]}) + (DIVN_W+2)'(qx);
    sy_full = (DIVN_W+2)'({1'b0, screen_height[DIM_W-1:1]}) - (DIVN_W+2)'(qy);
    if (sx_full > (DIVN_W+2)'(OUT_MAX)) begin
      sx_sat = OUT_W'(OUT_MAX);
    end else if (sx_full < (DIVN_W+2)'(OUT_MIN)) begin
      sx_sat = OUT_W'(OUT_MIN);
    end else begin
      sx_sat = OUT_W'(sx_full);
    end
    if (sy_full > (DIVN_W+2)'(OUT_MAX)) begin
      sy_sat = OUT_W'(OUT_MAX);
    end else if (sy_full < (DIVN_W+2)'(OUT_MIN)) begin
      sy_sat = OUT_W'(OUT_MIN);
    end else begin
      sy_sat = OUT_W'(sy_full);
    end
  end

  always_ff @(posedge clk) begin
    screen_x <= sx_sat;
    screen_y <= sy_sat;
  end

  assign result_strobe = v_out;

`include "vertex_rotate_project_defines.svh"

  `VRP_ASSERT_NEXT(a_setup_on_write, cfg_restart, busy, "trig rebuild not started after write")
  `VRP_ASSERT_NOW(a_strobe_latency, result_strobe, $past(start && !busy, PIPE_DEPTH), "result word without matching accept")
  `VRP_ASSERT_NOW(a_trig_hold, !busy && $past(!busy), $stable(sin_y) && $stable(cos_y) && $stable(sin_x) && $stable(cos_x) && $stable(scale), "trig table moved while idle")

endmodule

>>> design/vrp_div_pipe.sv
module vrp_div_pipe
  import vrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  vrp_div_in_t  din,
  output vrp_div_out_t dout
);

  // one quotient bit per stage, two lanes sharing the divisor
  typedef struct packed {
    logic [DEPTH_W-1:0] rem;
    logic [DIVN_W-1:0]  nq;   // dividend bits shift out the top, quotient in the bottom
  } vrp_lane_t;

  typedef struct packed {
    logic               neg_x;
    logic               neg_y;
    vrp_lane_t          lane_x;
    vrp_lane_t          lane_y;
    logic [DEPTH_W-1:0] divisor;
  } vrp_stage_t;

  function automatic vrp_lane_t div_step(vrp_lane_t cur, logic [DEPTH_W-1:0] d);
    logic [DEPTH_W:0] trial;
    logic             ge;
    vrp_lane_t        res;
    trial = {cur.rem, cur.nq[DIVN_W-1]};
    ge = (trial >= {1'b0, d});
    res.rem = DEPTH_W'(ge ? (trial - {1'b0, d}) : trial);
    res.nq = {cur.nq[DIVN_W-2:0], ge};
    return res;
  endfunction

  logic       stg_valid [DIVN_W];
  vrp_stage_t stg       [DIVN_W];

  for (genvar i = 0; i < DIVN_W; i++) begin : g_stage
    logic       prev_valid;
    vrp_stage_t prev;

    if (i == 0) begin : g_first
      always_comb begin
        prev_valid = din.valid;
        prev.neg_x = din.neg_x;
        prev.neg_y = din.neg_y;
        prev.lane_x.rem = '0;
        prev.lane_x.nq = din.mag_x;
        prev.lane_y.rem = '0;
        prev.lane_y.nq = din.mag_y;
        prev.divisor = din.divisor;
      end
    end else begin : g_rest
      always_comb begin
        prev_valid = stg_valid[i-1];
        prev = stg[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[i] <= 1'b0;
      end else begin
        stg_valid[i] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      stg[i].neg_x <= prev.neg_x;
      stg[i].neg_y <= prev.neg_y;
      stg[i].lane_x <= div_step(prev.lane_x, prev.divisor);
      stg[i].lane_y <= div_step(prev.lane_y, prev.divisor);
      stg[i].divisor <= prev.divisor;
    end
  end

  assign dout.valid  = stg_valid[DIVN_W-1];
  assign dout.neg_x  = stg[DIVN_W-1].neg_x;
  assign dout.neg_y  = stg[DIVN_W-1].neg_y;
  assign dout.quot_x = stg[DIVN_W-1].lane_x.nq;
  assign dout.quot_y = stg[DIVN_W-1].lane_y.nq;

`include "vertex_rotate_project_defines.svh"

  `VRP_ASSERT_NOW(a_divisor_floor, din.valid, din.divisor >= DEPTH_W'(DEPTH_MIN), "depth below clamp reached divider")

endmodule

>>> test/tb_vertex_rotate_project.sv
`timescale 1ns / 100ps

module tb_vertex_rotate_project;
  import vrp_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [VTX_W-1:0]  vertex_x;
  logic signed [VTX_W-1:0]  vertex_y;
  logic signed [VTX_W-1:0]  vertex_z;
  logic                     result_strobe;
  logic signed [OUT_W-1:0]  screen_x;
  logic signed [OUT_W-1:0]  screen_y;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DAT_W-1:0]     cfg_data;

  int idle_pct;

  vertex_rotate_project dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .vertex_z      (vertex_z),
    .result_strobe (result_strobe),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  typedef struct packed {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
  } screen_pos_t;

  class projection_checker;
    logic [ANG_W-1:0] ang_y;
    logic [ANG_W-1:0] ang_x;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    screen_pos_t      positions_due[$];
    int               errors;

    function new();
      ang_y  = '0;
      ang_x  = '0;
      width  = WIDTH_RESET;
      height = HEIGHT_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_ANGLE_Y: ang_y  = data[ANG_W-1:0];
        REG_ANGLE_X: ang_x  = data[ANG_W-1:0];
        REG_WIDTH:   width  = data[DIM_W-1:0];
        REG_HEIGHT:  height = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Bhaskara sine in Q10; sign flips on the lower half turn
    function longint sin_q10(int unsigned deg);
      longint a, t, sgn;
      a   = deg % FULL_TURN;
      sgn = 1;
      if (a > HALF_TURN) begin
        a   = a - HALF_TURN;
        sgn = -1;
      end
      t = a * (HALF_TURN - a);
      return sgn * ((t * 4 * 1024) / (BHASKARA_K - t));
    endfunction

    function longint clip_out(longint v);
      if (v > OUT_MAX) return OUT_MAX;
      if (v < OUT_MIN) return OUT_MIN;
      return v;
    endfunction

    function void note_vertex(logic signed [VTX_W-1:0] x, y, z);
      longint vx, vy, vz, sa, ca, sb, cb;
      longint xr, zr, yr, depth, scale;
      screen_pos_t pos;
      vx = x;
      vy = y;
      vz = z;
      sa = sin_q10(ang_y);
      ca = sin_q10(ang_y + QUARTER_TURN);
      sb = sin_q10(ang_x);
      cb = sin_q10(ang_x + QUARTER_TURN);
      // >>> on signed longint floors, matching the Q10 rounding
      xr    = (vx * ca + vz * sa) >>> Q10_SHIFT;
      zr    = (-vx * sa + vz * ca) >>> Q10_SHIFT;
      yr    = (vy * cb - zr * sb) >>> Q10_SHIFT;
      depth = ((vy * sb + zr * cb) >>> Q10_SHIFT) + DEPTH_OFFSET;
      if (depth < DEPTH_MIN) depth = DEPTH_MIN;
      scale  = (longint'(height) * 2) / SCALE_DEN;
      pos.sx = OUT_W'(clip_out(longint'(width) / 2 + (xr * scale) / depth));
      pos.sy = OUT_W'(clip_out(longint'(height) / 2 - (yr * scale) / depth));
      positions_due.push_back(pos);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] sx, sy);
      screen_pos_t pos;
      if (positions_due.size() == 0) begin
        $error("result word with nothing expected: screen_x %0d screen_y %0d", sx, sy);
        errors++;
        return;
      end
      pos = positions_due.pop_front();
      if (sx !== pos.sx) begin
        $error("screen_x: expected %0d, got %0d", pos.sx, sx);
        errors++;
      end
      if (sy !== pos.sy) begin
        $error("screen_y: expected %0d, got %0d", pos.sy, sy);
        errors++;
      end
    endfunction

    function int pending();
      return positions_due.size();
    endfunction
  endclass

  projection_checker chk = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) chk.check_result(screen_x, screen_y);
      if (start && !busy) chk.note_vertex(vertex_x, vertex_y, vertex_z);
      if (cfg_valid && cfg_ready) chk.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic drive_vertex(input int x, input int y, input int z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    vertex_x <= VTX_W'(x);
    vertex_y <= VTX_W'(y);
    vertex_z <= VTX_W'(z);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and let every outstanding word come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_view(input logic [CFG_DAT_W-1:0] ay, ax, w, h);
    drain();
    cfg_write(REG_ANGLE_Y, ay);
    cfg_write(REG_ANGLE_X, ax);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_angle();
    case ($urandom_range(5))
      0: return CFG_DAT_W'(0);
      1: return CFG_DAT_W'(359);
      2: return CFG_DAT_W'($urandom);  // junk above bit 8, wraps past 359
      default: return CFG_DAT_W'($urandom_range(359));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_dim();
    case ($urandom_range(6))
      0: return CFG_DAT_W'(1);
      1: return CFG_DAT_W'(4096);
      2: return CFG_DAT_W'($urandom);
      default: return CFG_DAT_W'($urandom_range(4096, 1));
    endcase
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(1)) return int'(VTX_W'($urandom));
    return int'($urandom_range(3072)) - 1536;
  endfunction

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    vertex_x  <= '0;
    vertex_y  <= '0;
    vertex_z  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    idle_pct  = 12;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset view: extremes, origin, behind and just in front of the eye
    drive_vertex(0, 0, 0);
    drive_vertex(4095, 4095, 4095);
    drive_vertex(-4096, -4096, -4096);
    drive_vertex(4095, -4096, 0);
    drive_vertex(-4096, 4095, -4096);
    drive_vertex(0, 0, -4096);
    drive_vertex(1024, 1024, -3060);
    drive_vertex(1, -1, 1);

    // 45/90 with max height: depth clamps and both outputs saturate
    set_view(45, 90, 8191, 8191);
    cfg_write(8'hFF, 16'hFFFF);
    drive_vertex(4095, -4096, 4095);
    drive_vertex(-4096, -4096, -4096);
    drive_vertex(-4096, -4096, 4095);
    drive_vertex(4095, -4096, -4096);

    // zero height collapses to the centre
    set_view(359, 511, 0, 0);
    drive_vertex(4095, 4095, -4096);
    drive_vertex(-4096, 0, 4095);
    drive_vertex(-1, -1, -1);

    set_view(180, 270, 1, 1);
    drive_vertex(4095, 4095, 4095);
    drive_vertex(-4096, 4095, 0);
    drive_vertex(0, -4096, -4096);

    set_view(16'hFFFF, 16'hFE00, 4096, 4096);
    drive_vertex(-4096, 4095, 4095);
    drive_vertex(4095, -4096, 2048);
    drive_vertex(0, 0, 4095);

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 12 : (ph < 8) ? 82 : 0;
      set_view(pick_angle(), pick_angle(), pick_dim(), pick_dim());
      if ($urandom_range(2) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(255, 4)), CFG_DAT_W'($urandom));
      for (int n = 0; n < 100; n++)
        drive_vertex(pick_coord(), pick_coord(), pick_coord());
    end

    drain();
    repeat (40) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("tb_vertex_rotate_project: clean");
    end else begin
      $display("tb_vertex_rotate_project: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_vertex_rotate_project: errors");
    $finish;
  end

endmodule
